// ===== hw/rtl/discharge_interval_logger_assert.svh =====
// ----------------------------------------------------------------------------
// Discharge interval logger assertion macros
// Shared property wrappers used by the logger's controller and datapath.
// ----------------------------------------------------------------------------
`ifndef DISCHARGE_INTERVAL_LOGGER_ASSERT_SVH
`define DISCHARGE_INTERVAL_LOGGER_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define DIL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("discharge interval logger: same-cycle property failed");

// Next-cycle implication, ignored while reset is held.
`define DIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("discharge interval logger: next-cycle property failed");

`endif

// ===== hw/rtl/dil_pkg.sv =====
// ----------------------------------------------------------------------------
// Discharge interval logger package
// Types, widths and codes shared by the logger's modules.
// ----------------------------------------------------------------------------
package dil_pkg;

  // Ring geometry.
  localparam int RING_DEPTH = 512;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int IDX_W      = 9;
  localparam int HELD_W     = 10;
  localparam int POS_W      = ((RING_AW > IDX_W) ? RING_AW : IDX_W) + 1;

  // Statistic widths.
  localparam int MS_W   = 42;
  localparam int DROP_W = 31;
  localparam int CNT_W  = 32;
  localparam int LITMS_W = 26;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef enum logic [2:0] {
    OP_RECORD     = 3'd0,
    OP_READ_ERROR = 3'd1,
    OP_READ_ENTRY = 3'd2,
    OP_READ_STAT  = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

  localparam logic [3:0] STAT_SUM_MS        = 4'd0;
  localparam logic [3:0] STAT_SUM_DROP      = 4'd1;
  localparam logic [3:0] STAT_IDLE_MS       = 4'd2;
  localparam logic [3:0] STAT_IDLE_DROP     = 4'd3;
  localparam logic [3:0] STAT_LIT_MS        = 4'd4;
  localparam logic [3:0] STAT_SKIPS         = 4'd5;
  localparam logic [3:0] STAT_ERRORS        = 4'd6;
  localparam logic [3:0] STAT_ANCHOR_TIME   = 4'd7;
  localparam logic [3:0] STAT_ANCHOR_CHARGE = 4'd8;
  localparam logic [3:0] STAT_LAST_TIME     = 4'd9;
  localparam logic [3:0] STAT_LAST_CHARGE   = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_UPD,
    ST_RESP
  } state_t;

  // One ring entry apart from its time stamp.
  typedef struct packed {
    logic [15:0] rate;
    logic [15:0] lit;
    logic [12:0] mv;
    logic [15:0] charge;
  } ring_fields_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic update;
    logic resp_load;
  } cmd_t;

endpackage

// ===== hw/rtl/dil_datapath.sv =====
// ----------------------------------------------------------------------------
// Discharge interval logger datapath
// Sample ring, interval arithmetic, running totals and the result register.
// ----------------------------------------------------------------------------
`include "discharge_interval_logger_assert.svh"

module dil_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  dil_pkg::cmd_t       cmd,
  input  logic [2:0]          in_opcode,
  input  logic [31:0]         in_uptime_s,
  input  logic [15:0]         in_charge_q8,
  input  logic [12:0]         in_cell_mv,
  input  logic [15:0]         in_lit_s,
  input  logic signed [15:0]  in_rate_raw,
  input  logic [8:0]          in_entry_index,
  input  logic [3:0]          in_stat_select,
  output logic [9:0]          out_held_count,
  output logic                out_entry_valid,
  output logic [31:0]         out_entry_uptime_s,
  output logic [15:0]         out_entry_charge_q8,
  output logic [12:0]         out_entry_cell_mv,
  output logic [15:0]         out_entry_lit_s,
  output logic signed [15:0]  out_entry_rate_raw,
  output logic [41:0]         out_stat_value,
  output logic                out_anchor_present
);

  localparam int AW = dil_pkg::RING_AW;
  localparam int FW = dil_pkg::FILL_W;
  localparam int PW = dil_pkg::POS_W;

  // Captured request.
  dil_pkg::op_t               op_r;
  logic [31:0]                now_r;
  logic [15:0]                charge_r;
  logic [12:0]                mv_r;
  logic [15:0]                lit_r;
  logic [15:0]                rate_r;
  logic [dil_pkg::IDX_W-1:0]  idx_r;
  logic [3:0]                 sel_r;

  // Sample ring.
  logic [31:0]                ring_time [dil_pkg::RING_DEPTH];
  dil_pkg::ring_fields_t      ring_fields [dil_pkg::RING_DEPTH];
  logic [31:0]                rd_time_r;
  dil_pkg::ring_fields_t      rd_fields_r;

  // Interval terms computed in the execute step.
  logic [dil_pkg::MS_W-1:0]    span_ms_r;
  logic [dil_pkg::LITMS_W-1:0] lit_ms_r;
  logic [15:0]                 drop_r;
  logic                        rise_r;
  logic                        span_zero_r;
  logic [31:0]                 span32;

  // Logger state.
  logic [AW-1:0]               write_pos_r, write_pos_nxt;
  logic [FW-1:0]               fill_count_r, fill_count_nxt;
  logic                        anchor_r, anchor_nxt;
  logic [31:0]                 anchor_time_r, anchor_time_nxt;
  logic [15:0]                 anchor_charge_r, anchor_charge_nxt;
  logic [31:0]                 last_time_r, last_time_nxt;
  logic [15:0]                 last_charge_r, last_charge_nxt;
  logic [dil_pkg::MS_W-1:0]    sum_ms_r, sum_ms_nxt;
  logic [dil_pkg::DROP_W-1:0]  sum_drop_r, sum_drop_nxt;
  logic [dil_pkg::MS_W-1:0]    idle_ms_r, idle_ms_nxt;
  logic [dil_pkg::DROP_W-1:0]  idle_drop_r, idle_drop_nxt;
  logic [dil_pkg::MS_W-1:0]    lit_sum_r, lit_sum_nxt;
  logic [dil_pkg::CNT_W-1:0]   skip_r, skip_nxt;
  logic [dil_pkg::CNT_W-1:0]   error_r, error_nxt;

  // Saturating sums.
  logic [dil_pkg::MS_W:0]      sum_ms_add, idle_ms_add, lit_sum_add;
  logic [dil_pkg::DROP_W:0]    sum_drop_add, idle_drop_add;

  // Read addressing.
  logic [PW-1:0]               start_pos, pos_sum;
  logic [AW-1:0]               rd_pos;
  logic                        ring_full;
  logic                        idx_in_range;

  // Result register.
  logic [9:0]                  held_r;
  logic                        ent_valid_r;
  logic [31:0]                 ent_time_r;
  dil_pkg::ring_fields_t       ent_fields_r;
  logic [41:0]                 stat_r;
  logic                        anchor_out_r;
  logic [41:0]                 stat_mux;

  // Update step of a clear request.
  logic                        clear_upd;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= dil_pkg::op_t'(in_opcode);
      now_r    <= in_uptime_s;
      charge_r <= in_charge_q8;
      mv_r     <= in_cell_mv;
      lit_r    <= in_lit_s;
      rate_r   <= in_rate_raw;
      idx_r    <= in_entry_index;
      sel_r    <= in_stat_select;
    end
  end

  // Oldest entry sits at the write position once the ring has wrapped.
  assign ring_full    = (fill_count_r == FW'(dil_pkg::RING_DEPTH));
  assign start_pos    = ring_full ? PW'(write_pos_r) : '0;
  assign pos_sum      = start_pos + PW'(idx_r);
  assign rd_pos       = (pos_sum >= PW'(dil_pkg::RING_DEPTH)) ?
                        AW'(pos_sum - PW'(dil_pkg::RING_DEPTH)) : AW'(pos_sum);
  assign idx_in_range = (PW'(idx_r) < PW'(fill_count_r));

  always_ff @(posedge clk) begin
    if (cmd.exec && (op_r == dil_pkg::OP_RECORD)) begin
      ring_time[write_pos_r]   <= now_r;
      ring_fields[write_pos_r] <= '{rate: rate_r, lit: lit_r, mv: mv_r, charge: charge_r};
    end
    if (cmd.exec && (op_r == dil_pkg::OP_READ_ENTRY)) begin
      rd_time_r   <= ring_time[rd_pos];
      rd_fields_r <= ring_fields[rd_pos];
    end
  end

  // Interval length wraps modulo 2^32, so a backward time step is a long interval.
  assign span32 = now_r - last_time_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      span_ms_r   <= {10'd0, span32} * {32'd0, dil_pkg::MS_PER_S};
      lit_ms_r    <= {10'd0, lit_r} * {16'd0, dil_pkg::MS_PER_S};
      drop_r      <= last_charge_r - charge_r;
      rise_r      <= (charge_r > last_charge_r);
      span_zero_r <= (span32 == 32'd0);
    end
  end

  assign sum_ms_add    = {1'b0, sum_ms_r} + {1'b0, span_ms_r};
  assign idle_ms_add   = {1'b0, idle_ms_r} + {1'b0, span_ms_r};
  assign lit_sum_add   = {1'b0, lit_sum_r} + (dil_pkg::MS_W + 1)'(lit_ms_r);
  assign sum_drop_add  = {1'b0, sum_drop_r} + (dil_pkg::DROP_W + 1)'(drop_r);
  assign idle_drop_add = {1'b0, idle_drop_r} + (dil_pkg::DROP_W + 1)'(drop_r);

  always_comb begin
    write_pos_nxt     = write_pos_r;
    fill_count_nxt    = fill_count_r;
    anchor_nxt        = anchor_r;
    anchor_time_nxt   = anchor_time_r;
    anchor_charge_nxt = anchor_charge_r;
    last_time_nxt     = last_time_r;
    last_charge_nxt   = last_charge_r;
    sum_ms_nxt        = sum_ms_r;
    sum_drop_nxt      = sum_drop_r;
    idle_ms_nxt       = idle_ms_r;
    idle_drop_nxt     = idle_drop_r;
    lit_sum_nxt       = lit_sum_r;
    skip_nxt          = skip_r;
    error_nxt         = error_r;
    if (cmd.update) begin
      case (op_r)
        dil_pkg::OP_RECORD: begin
          if (!anchor_r) begin
            anchor_nxt        = 1'b1;
            anchor_time_nxt   = now_r;
            anchor_charge_nxt = charge_r;
          end else if (!span_zero_r) begin
            if (rise_r) begin
              if (skip_r != '1) begin
                skip_nxt = skip_r + 1'b1;
              end
            end else begin
              sum_ms_nxt   = sum_ms_add[dil_pkg::MS_W] ? '1 : sum_ms_add[dil_pkg::MS_W-1:0];
              sum_drop_nxt = sum_drop_add[dil_pkg::DROP_W] ? '1 :
                             sum_drop_add[dil_pkg::DROP_W-1:0];
              lit_sum_nxt  = lit_sum_add[dil_pkg::MS_W] ? '1 : lit_sum_add[dil_pkg::MS_W-1:0];
              if (lit_r == 16'd0) begin
                idle_ms_nxt   = idle_ms_add[dil_pkg::MS_W] ? '1 :
                                idle_ms_add[dil_pkg::MS_W-1:0];
                idle_drop_nxt = idle_drop_add[dil_pkg::DROP_W] ? '1 :
                                idle_drop_add[dil_pkg::DROP_W-1:0];
              end
            end
          end
          last_time_nxt   = now_r;
          last_charge_nxt = charge_r;
          write_pos_nxt   = (write_pos_r == AW'(dil_pkg::RING_DEPTH - 1)) ? '0 :
                            write_pos_r + 1'b1;
          if (!ring_full) begin
            fill_count_nxt = fill_count_r + 1'b1;
          end
        end
        dil_pkg::OP_READ_ERROR: begin
          if (error_r != '1) begin
            error_nxt = error_r + 1'b1;
          end
        end
        dil_pkg::OP_CLEAR: begin
          write_pos_nxt     = '0;
          fill_count_nxt    = '0;
          anchor_nxt        = 1'b0;
          anchor_time_nxt   = '0;
          anchor_charge_nxt = '0;
          last_time_nxt     = '0;
          last_charge_nxt   = '0;
          sum_ms_nxt        = '0;
          sum_drop_nxt      = '0;
          idle_ms_nxt       = '0;
          idle_drop_nxt     = '0;
          lit_sum_nxt       = '0;
          skip_nxt          = '0;
          error_nxt         = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r     <= '0;
      fill_count_r    <= '0;
      anchor_r        <= 1'b0;
      anchor_time_r   <= '0;
      anchor_charge_r <= '0;
      last_time_r     <= '0;
      last_charge_r   <= '0;
      sum_ms_r        <= '0;
      sum_drop_r      <= '0;
      idle_ms_r       <= '0;
      idle_drop_r     <= '0;
      lit_sum_r       <= '0;
      skip_r          <= '0;
      error_r         <= '0;
    end else begin
      write_pos_r     <= write_pos_nxt;
      fill_count_r    <= fill_count_nxt;
      anchor_r        <= anchor_nxt;
      anchor_time_r   <= anchor_time_nxt;
      anchor_charge_r <= anchor_charge_nxt;
      last_time_r     <= last_time_nxt;
      last_charge_r   <= last_charge_nxt;
      sum_ms_r        <= sum_ms_nxt;
      sum_drop_r      <= sum_drop_nxt;
      idle_ms_r       <= idle_ms_nxt;
      idle_drop_r     <= idle_drop_nxt;
      lit_sum_r       <= lit_sum_nxt;
      skip_r          <= skip_nxt;
      error_r         <= error_nxt;
    end
  end

  always_comb begin
    stat_mux = '0;
    if (op_r == dil_pkg::OP_READ_STAT) begin
      case (sel_r)
        dil_pkg::STAT_SUM_MS:        stat_mux = sum_ms_r;
        dil_pkg::STAT_SUM_DROP:      stat_mux = 42'(sum_drop_r);
        dil_pkg::STAT_IDLE_MS:       stat_mux = idle_ms_r;
        dil_pkg::STAT_IDLE_DROP:     stat_mux = 42'(idle_drop_r);
        dil_pkg::STAT_LIT_MS:        stat_mux = lit_sum_r;
        dil_pkg::STAT_SKIPS:         stat_mux = 42'(skip_r);
        dil_pkg::STAT_ERRORS:        stat_mux = 42'(error_r);
        dil_pkg::STAT_ANCHOR_TIME:   stat_mux = 42'(anchor_time_r);
        dil_pkg::STAT_ANCHOR_CHARGE: stat_mux = 42'(anchor_charge_r);
        dil_pkg::STAT_LAST_TIME:     stat_mux = 42'(last_time_r);
        dil_pkg::STAT_LAST_CHARGE:   stat_mux = 42'(last_charge_r);
        default:                     stat_mux = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      held_r       <= (dil_pkg::HELD_W)'(fill_count_r);
      anchor_out_r <= anchor_r;
      stat_r       <= stat_mux;
      if ((op_r == dil_pkg::OP_READ_ENTRY) && idx_in_range) begin
        ent_valid_r  <= 1'b1;
        ent_time_r   <= rd_time_r;
        ent_fields_r <= rd_fields_r;
      end else begin
        ent_valid_r  <= 1'b0;
        ent_time_r   <= '0;
        ent_fields_r <= '0;
      end
    end
  end

  assign out_held_count      = held_r;
  assign out_entry_valid     = ent_valid_r;
  assign out_entry_uptime_s  = ent_time_r;
  assign out_entry_charge_q8 = ent_fields_r.charge;
  assign out_entry_cell_mv   = ent_fields_r.mv;
  assign out_entry_lit_s     = ent_fields_r.lit;
  assign out_entry_rate_raw  = ent_fields_r.rate;
  assign out_stat_value      = stat_r;
  assign out_anchor_present  = anchor_out_r;

  assign clear_upd = cmd.update && (op_r == dil_pkg::OP_CLEAR);

  `DIL_ASSERT_IMPL(a_fill_bounded, clk, rst_n, 1'b1, fill_count_r <= FW'(dil_pkg::RING_DEPTH))
  `DIL_ASSERT_IMPL(a_pos_tracks_fill, clk, rst_n, !ring_full, FW'(write_pos_r) == fill_count_r)
  `DIL_ASSERT_NEXT(a_clear_empties, clk, rst_n, clear_upd, (fill_count_r == '0) && !anchor_r)

endmodule

// ===== hw/rtl/dil_ctrl.sv =====
// ----------------------------------------------------------------------------
// Discharge interval logger controller
// Sequences capture, execute, update and result load for one request.
// ----------------------------------------------------------------------------
`include "discharge_interval_logger_assert.svh"

module dil_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dil_pkg::cmd_t  cmd
);

  dil_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;
  logic            resp_fire;

  assign slot_free = !out_valid_r || out_ready;
  assign resp_fire = (state_r == dil_pkg::ST_RESP) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dil_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      dil_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = dil_pkg::ST_EXEC;
        end
      end
      dil_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = dil_pkg::ST_UPD;
      end
      dil_pkg::ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = dil_pkg::ST_RESP;
      end
      dil_pkg::ST_RESP: begin
        if (slot_free) begin
          cmd.resp_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = dil_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dil_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `DIL_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, in_valid && in_ready, state_r == dil_pkg::ST_EXEC)
  `DIL_ASSERT_NEXT(a_exec_to_upd, clk, rst_n, state_r == dil_pkg::ST_EXEC, state_r == dil_pkg::ST_UPD)
  `DIL_ASSERT_NEXT(a_resp_loads, clk, rst_n, resp_fire, out_valid_r && (state_r == dil_pkg::ST_IDLE))

endmodule

// ===== hw/rtl/discharge_interval_logger.sv =====
// ----------------------------------------------------------------------------
// Discharge interval logger
// Battery sample ring with saturating discharge interval statistics.
// ----------------------------------------------------------------------------
// Each request (record a sample, count a read error, read a ring entry with
// index 0 the oldest held, read a statistic, or clear) produces exactly one
// result transfer. The transfer edge captures the request; the execute step
// then performs the ring access and the interval products (the ring is a
// synchronous memory with a registered read port, and the time span is
// scaled to milliseconds by a registered multiply), the update step the
// saturating accumulations, and the result step loads the result register.
// A new request is taken only when the controller is back at rest, so the
// block finishes one request before it takes the next. The result register
// lets the next request be taken while the previous result is still
// waiting; a result side that stalls for longer holds the controller in its
// final step. The ring contents are never cleared; reading beyond the number
// of held samples returns a zeroed entry with entry_valid low, so unwritten
// locations are never seen.
// ----------------------------------------------------------------------------

module discharge_interval_logger (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_opcode,
  input  logic [31:0]         in_uptime_s,
  input  logic [15:0]         in_charge_q8,
  input  logic [12:0]         in_cell_mv,
  input  logic [15:0]         in_lit_s,
  input  logic signed [15:0]  in_rate_raw,
  input  logic [8:0]          in_entry_index,
  input  logic [3:0]          in_stat_select,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [9:0]          out_held_count,
  output logic                out_entry_valid,
  output logic [31:0]         out_entry_uptime_s,
  output logic [15:0]         out_entry_charge_q8,
  output logic [12:0]         out_entry_cell_mv,
  output logic [15:0]         out_entry_lit_s,
  output logic signed [15:0]  out_entry_rate_raw,
  output logic [41:0]         out_stat_value,
  output logic                out_anchor_present
);

  // Commands from the sequencer; the datapath reports nothing back, as every
  // request follows the same fixed sequence of steps.
  dil_pkg::cmd_t cmd;

  dil_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath holds the ring, the anchor and latest sample, the running
  // totals and the result register that the controller loads once per request.
  dil_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_opcode           (in_opcode),
    .in_uptime_s         (in_uptime_s),
    .in_charge_q8        (in_charge_q8),
    .in_cell_mv          (in_cell_mv),
    .in_lit_s            (in_lit_s),
    .in_rate_raw         (in_rate_raw),
    .in_entry_index      (in_entry_index),
    .in_stat_select      (in_stat_select),
    .out_held_count      (out_held_count),
    .out_entry_valid     (out_entry_valid),
    .out_entry_uptime_s  (out_entry_uptime_s),
    .out_entry_charge_q8 (out_entry_charge_q8),
    .out_entry_cell_mv   (out_entry_cell_mv),
    .out_entry_lit_s     (out_entry_lit_s),
    .out_entry_rate_raw  (out_entry_rate_raw),
    .out_stat_value      (out_stat_value),
    .out_anchor_present  (out_anchor_present)
  );

endmodule

// ===== dv/discharge_interval_logger_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Discharge interval logger testbench
// Drives logging, error, entry-read, statistic-read and clear requests through
// the request channel, predicts every result transfer from a behavioural copy
// of the sample ring and interval totals, and checks each result field by
// field. The sender works in bursts and the receiver stalls on patterns.
// ----------------------------------------------------------------------------

module discharge_interval_logger_tb;

  // Widths and geometry taken from the package.
  localparam int RING_DEPTH = dil_pkg::RING_DEPTH;
  localparam int RING_AW    = dil_pkg::RING_AW;
  localparam int HELD_W     = dil_pkg::HELD_W;
  localparam int MS_W       = dil_pkg::MS_W;
  localparam int DROP_W     = dil_pkg::DROP_W;
  localparam int CNT_W      = dil_pkg::CNT_W;
  localparam logic [9:0] MS_PER_S = dil_pkg::MS_PER_S;

  // Run shape. Clears are only allowed early on, so that the long tail of
  // mostly recorded samples wraps the ring.
  localparam int RANDOM_ITEMS  = 620;
  localparam int CLEAR_WINDOW  = 30;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  localparam logic [63:0] MS_MAX   = (64'd1 << MS_W) - 64'd1;
  localparam logic [63:0] DROP_MAX = (64'd1 << DROP_W) - 64'd1;
  localparam logic [63:0] CNT_MAX  = (64'd1 << CNT_W) - 64'd1;

  // One request as it goes through the input channel. drain_first makes the
  // sender hold back this request until every earlier result has arrived.
  typedef struct packed {
    logic        drain_first;
    logic [2:0]  opcode;
    logic [31:0] uptime;
    logic [15:0] charge;
    logic [12:0] mv;
    logic [15:0] lit;
    logic [15:0] rate;
    logic [8:0]  index;
    logic [3:0]  sel;
  } request_t;

  // One result as it should come out of the result channel.
  typedef struct packed {
    logic [HELD_W-1:0] held;
    logic              entry_ok;
    logic [31:0]       e_uptime;
    logic [15:0]       e_charge;
    logic [12:0]       e_mv;
    logic [15:0]       e_lit;
    logic [15:0]       e_rate;
    logic [MS_W-1:0]   stat;
    logic              anchor;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_opcode = '0;
  logic [31:0] in_uptime_s = '0;
  logic [15:0] in_charge_q8 = '0;
  logic [12:0] in_cell_mv = '0;
  logic [15:0] in_lit_s = '0;
  logic signed [15:0] in_rate_raw = '0;
  logic [8:0]  in_entry_index = '0;
  logic [3:0]  in_stat_select = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_held_count;
  logic        out_entry_valid;
  logic [31:0] out_entry_uptime_s;
  logic [15:0] out_entry_charge_q8;
  logic [12:0] out_entry_cell_mv;
  logic [15:0] out_entry_lit_s;
  logic signed [15:0] out_entry_rate_raw;
  logic [41:0] out_stat_value;
  logic        out_anchor_present;

  discharge_interval_logger u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_uptime_s         (in_uptime_s),
    .in_charge_q8        (in_charge_q8),
    .in_cell_mv          (in_cell_mv),
    .in_lit_s            (in_lit_s),
    .in_rate_raw         (in_rate_raw),
    .in_entry_index      (in_entry_index),
    .in_stat_select      (in_stat_select),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_held_count      (out_held_count),
    .out_entry_valid     (out_entry_valid),
    .out_entry_uptime_s  (out_entry_uptime_s),
    .out_entry_charge_q8 (out_entry_charge_q8),
    .out_entry_cell_mv   (out_entry_cell_mv),
    .out_entry_lit_s     (out_entry_lit_s),
    .out_entry_rate_raw  (out_entry_rate_raw),
    .out_stat_value      (out_stat_value),
    .out_anchor_present  (out_anchor_present)
  );

  always begin
    #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioural copy of the logger: the sample ring, its write pointer and
  // fill level, the anchor and the previous sample, and the saturating totals.
  // --------------------------------------------------------------------------
  logic [31:0]           ring_stamp [RING_DEPTH];
  dil_pkg::ring_fields_t ring_body  [RING_DEPTH];
  logic [RING_AW-1:0]    wr_ptr;
  logic [HELD_W-1:0]     held;
  logic                  anchor_seen;
  logic [31:0]           anchor_stamp;
  logic [15:0]           anchor_level;
  logic [31:0]           last_stamp;
  logic [15:0]           last_level;
  logic [MS_W-1:0]       time_total;
  logic [DROP_W-1:0]     total_drop;
  logic [MS_W-1:0]       idle_ms;
  logic [DROP_W-1:0]     idle_drop;
  logic [MS_W-1:0]       lit_ms;
  logic [CNT_W-1:0]      skips;
  logic [CNT_W-1:0]      err_tally;

  // What the run has been through, for the closing summary.
  int n_samples, n_entry_reads, n_entry_hits, n_stat_reads, n_clears, n_other;
  int peak_held;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] top);
    logic [63:0] s;
    s = a + b;
    return (s > top) ? top : s;
  endfunction

  // Everything but the ring contents goes back to zero, as after a clear.
  function automatic void clear_log();
    wr_ptr = '0;
    held = '0;
    anchor_seen = 1'b0;
    anchor_stamp = '0;
    anchor_level = '0;
    last_stamp = '0;
    last_level = '0;
    time_total = '0;
    total_drop = '0;
    idle_ms = '0;
    idle_drop = '0;
    lit_ms = '0;
    skips = '0;
    err_tally = '0;
  endfunction

  // Applies one accepted request to the behavioural copy and returns the
  // result that the block must send for it.
  function automatic reply_t log_request(request_t rq);
    reply_t      r;
    logic [31:0] gap_s;
    logic [63:0] span;
    logic [63:0] drop;
    int unsigned pos;
    r = '0;
    case (rq.opcode)
      dil_pkg::OP_RECORD: begin
        n_samples++;
        if (!anchor_seen) begin
          anchor_seen = 1'b1;
          anchor_stamp = rq.uptime;
          anchor_level = rq.charge;
        end else begin
          // The time step wraps modulo 2^32, so a step backwards in time is
          // taken as a very long interval.
          gap_s = rq.uptime - last_stamp;
          span = {32'b0, gap_s} * MS_PER_S;
          if (span == 0) begin
            // A zero-length interval leaves every total alone.
          end else if (rq.charge > last_level) begin
            // Charge went up: a charging interval, counted and skipped.
            skips = CNT_W'(sat_add(64'(skips), 64'd1, CNT_MAX));
          end else begin
            drop = {48'b0, last_level - rq.charge};
            time_total = MS_W'(sat_add(64'(time_total), span, MS_MAX));
            total_drop = DROP_W'(sat_add(64'(total_drop), drop, DROP_MAX));
            lit_ms = MS_W'(sat_add(64'(lit_ms), {48'b0, rq.lit} * MS_PER_S, MS_MAX));
            if (rq.lit == 0) begin
              idle_ms = MS_W'(sat_add(64'(idle_ms), span, MS_MAX));
              idle_drop = DROP_W'(sat_add(64'(idle_drop), drop, DROP_MAX));
            end
          end
        end
        last_stamp = rq.uptime;
        last_level = rq.charge;
        ring_stamp[wr_ptr] = rq.uptime;
        ring_body[wr_ptr] = '{rate: rq.rate, lit: rq.lit, mv: rq.mv, charge: rq.charge};
        wr_ptr = wr_ptr + 1'b1;
        if (held < RING_DEPTH) held = held + 1'b1;
        if (int'(held) > peak_held) peak_held = int'(held);
      end
      dil_pkg::OP_READ_ERROR: begin
        n_other++;
        err_tally = CNT_W'(sat_add(64'(err_tally), 64'd1, CNT_MAX));
      end
      dil_pkg::OP_READ_ENTRY: begin
        n_entry_reads++;
        // Index 0 is the oldest sample held: once the ring has wrapped that is
        // the slot about to be overwritten next.
        if (rq.index < held) begin
          n_entry_hits++;
          pos = (held == RING_DEPTH) ? wr_ptr : 0;
          pos = (pos + rq.index) % RING_DEPTH;
          r.entry_ok = 1'b1;
          r.e_uptime = ring_stamp[pos];
          r.e_charge = ring_body[pos].charge;
          r.e_mv = ring_body[pos].mv;
          r.e_lit = ring_body[pos].lit;
          r.e_rate = ring_body[pos].rate;
        end
      end
      dil_pkg::OP_READ_STAT: begin
        n_stat_reads++;
        case (rq.sel)
          dil_pkg::STAT_SUM_MS:        r.stat = time_total;
          dil_pkg::STAT_SUM_DROP:      r.stat = MS_W'(total_drop);
          dil_pkg::STAT_IDLE_MS:       r.stat = idle_ms;
          dil_pkg::STAT_IDLE_DROP:     r.stat = MS_W'(idle_drop);
          dil_pkg::STAT_LIT_MS:        r.stat = lit_ms;
          dil_pkg::STAT_SKIPS:         r.stat = MS_W'(skips);
          dil_pkg::STAT_ERRORS:        r.stat = MS_W'(err_tally);
          dil_pkg::STAT_ANCHOR_TIME:   r.stat = MS_W'(anchor_stamp);
          dil_pkg::STAT_ANCHOR_CHARGE: r.stat = MS_W'(anchor_level);
          dil_pkg::STAT_LAST_TIME:     r.stat = MS_W'(last_stamp);
          dil_pkg::STAT_LAST_CHARGE:   r.stat = MS_W'(last_level);
          default:                     r.stat = '0;
        endcase
      end
      dil_pkg::OP_CLEAR: begin
        n_clears++;
        clear_log();
      end
      default: begin
        // Unused opcodes change nothing and only report the state.
        n_other++;
      end
    endcase
    r.held = held;
    r.anchor = anchor_seen;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request stream. The initial block fills pending_requests; the driver
  // below takes them one by one. gen_fill follows the ring's fill level so
  // that most entry reads land on held samples.
  // --------------------------------------------------------------------------
  request_t pending_requests[$];
  reply_t   replies_due[$];
  int       gen_fill;
  int       mismatch_count;
  int       replies_checked;

  function automatic void queue_request(request_t rq);
    pending_requests.push_back(rq);
    if (rq.opcode == dil_pkg::OP_RECORD && gen_fill < RING_DEPTH) gen_fill++;
    else if (rq.opcode == dil_pkg::OP_CLEAR) gen_fill = 0;
  endfunction

  function automatic request_t sample_req(logic [31:0] t, logic [15:0] q, logic [12:0] mv,
                                          logic [15:0] lit, logic [15:0] rate);
    request_t rq;
    rq = '0;
    rq.opcode = dil_pkg::OP_RECORD;
    rq.uptime = t;
    rq.charge = q;
    rq.mv = mv;
    rq.lit = lit;
    rq.rate = rate;
    return rq;
  endfunction

  function automatic request_t op_req(logic [2:0] op, logic [8:0] idx, logic [3:0] sel);
    request_t rq;
    rq = '0;
    rq.opcode = op;
    rq.index = idx;
    rq.sel = sel;
    return rq;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers requests in bursts of random length with random gaps, and
  // keeps a request steady until its transfer. The expected result is worked
  // out at the edge where the transfer happens.
  // --------------------------------------------------------------------------
  request_t cur_req;
  int       burst_left = 1;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        replies_due.push_back(log_request(cur_req));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() == 0 ||
                     (pending_requests[0].drain_first && replies_due.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          cur_req = pending_requests.pop_front();
          in_opcode      <= cur_req.opcode;
          in_uptime_s    <= cur_req.uptime;
          in_charge_q8   <= cur_req.charge;
          in_cell_mv     <= cur_req.mv;
          in_lit_s       <= cur_req.lit;
          in_rate_raw    <= cur_req.rate;
          in_entry_index <= cur_req.index;
          in_stat_select <= cur_req.sel;
          in_valid       <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // A quarter of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: out_ready follows an eight-bit rotating pattern that is redrawn
  // at random intervals; a third of the patterns never stall.
  // Twice in the run it holds off for a long stretch so that the result
  // register fills and the block stops taking requests.
  // --------------------------------------------------------------------------
  logic [7:0] ready_pattern = 8'hFF;
  int         pattern_left = 40;
  int         hold_left = 0;
  int         rx_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rx_count++;
        if (rx_count == 120 || rx_count == 450) hold_left = LONG_HOLD;
      end
      if (pattern_left > 1) begin
        pattern_left--;
        ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
      end else begin
        pattern_left = $urandom_range(20, 80);
        ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ready_pattern[0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every result transfer is compared with the oldest expectation.
  // --------------------------------------------------------------------------
  reply_t want;

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        check_field("held_count", 64'(want.held), 64'(out_held_count));
        check_field("entry_valid", 64'(want.entry_ok), 64'(out_entry_valid));
        check_field("entry_uptime_s", 64'(want.e_uptime), 64'(out_entry_uptime_s));
        check_field("entry_charge_q8", 64'(want.e_charge), 64'(out_entry_charge_q8));
        check_field("entry_cell_mv", 64'(want.e_mv), 64'(out_entry_cell_mv));
        check_field("entry_lit_s", 64'(want.e_lit), 64'(out_entry_lit_s));
        check_field("entry_rate_raw", 64'(want.e_rate), 64'($unsigned(out_entry_rate_raw)));
        check_field("stat_value", 64'(want.stat), 64'(out_stat_value));
        check_field("anchor_present", 64'(want.anchor), 64'(out_anchor_present));
        replies_checked++;
      end
    end
  end

  // Hard stop in case the block hangs.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, replies_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    request_t    rq;
    logic [31:0] gen_time;
    logic [15:0] gen_charge;
    int          roll;
    int          step;
    int          drop_by;

    clear_log();
    gen_fill = 0;
    mismatch_count = 0;
    replies_checked = 0;

    // Directed part. An entry read before any sample must come back empty.
    queue_request(op_req(dil_pkg::OP_READ_ENTRY, 9'd0, dil_pkg::STAT_SUM_MS));
    // The first sample becomes the anchor, with every field at an extreme.
    queue_request(sample_req(32'hFFFF_FFF0, 16'hFFFF, 13'd5119, 16'hFFFF, 16'h8000));
    // Same uptime again: a zero-length interval.
    queue_request(sample_req(32'hFFFF_FFF0, 16'h8000, 13'd4096, 16'h0000, 16'h7FFF));
    // Time wraps forward past 2^32 while the charge rises: a skipped interval.
    queue_request(sample_req(32'h0000_0054, 16'hFFFF, 13'd1, 16'h0001, 16'h0001));
    // A plain discharge with the screen off feeds the idle totals.
    queue_request(sample_req(32'h0000_00F0, 16'h1000, 13'd2048, 16'h0000, 16'hFFFF));
    // Steps backwards in time count as near-2^32-second intervals, which
    // drive the millisecond totals into saturation.
    queue_request(sample_req(32'h0000_00EF, 16'h0800, 13'd5119, 16'hFFFF, 16'h0000));
    queue_request(sample_req(32'h0000_00EE, 16'h0000, 13'd0, 16'h0000, 16'h8000));
    queue_request(sample_req(32'h0000_00ED, 16'h0000, 13'd1000, 16'h0000, 16'h1234));
    queue_request(op_req(dil_pkg::OP_READ_ERROR, 9'd0, dil_pkg::STAT_SUM_MS));
    queue_request(op_req(OP_FIRST_UNUSED, 9'd0, dil_pkg::STAT_SUM_MS));
    // Every statistic, plus one select beyond the last.
    for (int s = dil_pkg::STAT_SUM_MS; s <= dil_pkg::STAT_LAST_CHARGE + 1; s++) begin
      queue_request(op_req(dil_pkg::OP_READ_STAT, 9'd0, 4'(s)));
    end
    queue_request(op_req(dil_pkg::OP_READ_ENTRY, 9'd0, dil_pkg::STAT_SUM_MS));
    queue_request(op_req(dil_pkg::OP_READ_ENTRY, 9'd7, dil_pkg::STAT_SUM_MS));
    queue_request(op_req(dil_pkg::OP_READ_ENTRY, 9'd511, dil_pkg::STAT_SUM_MS));
    queue_request(op_req(OP_LAST_UNUSED, 9'd0, dil_pkg::STAT_SUM_MS));
    queue_request(op_req(dil_pkg::OP_CLEAR, 9'd0, dil_pkg::STAT_SUM_MS));
    queue_request(op_req(dil_pkg::OP_READ_STAT, 9'd0, dil_pkg::STAT_ANCHOR_TIME));

    // Random part: mostly a plausible discharge log with random content, a
    // share of noise samples, and reads of every kind in between.
    gen_time = $urandom;
    gen_charge = 16'hFFFF;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      rq.drain_first = (i == 0 || i == CLEAR_WINDOW);
      rq.uptime = $urandom;
      rq.charge = 16'($urandom);
      rq.mv = 13'($urandom_range(0, 5119));
      rq.lit = 16'($urandom);
      rq.rate = 16'($urandom);
      rq.index = 9'($urandom);
      rq.sel = 4'($urandom);
      roll = $urandom_range(0, 99);
      if (i < CLEAR_WINDOW) begin
        rq.opcode = (roll < 55) ? dil_pkg::OP_RECORD :
                    (roll < 67) ? dil_pkg::OP_READ_ENTRY :
                    (roll < 79) ? dil_pkg::OP_READ_STAT :
                    (roll < 85) ? dil_pkg::OP_READ_ERROR :
                    (roll < 93) ? dil_pkg::OP_CLEAR :
                    3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end else begin
        rq.opcode = (roll < 93) ? dil_pkg::OP_RECORD :
                    (roll < 96) ? dil_pkg::OP_READ_ENTRY :
                    (roll < 98) ? dil_pkg::OP_READ_STAT :
                    (roll < 99) ? dil_pkg::OP_READ_ERROR :
                    3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end
      if (rq.opcode == dil_pkg::OP_RECORD && $urandom_range(0, 99) >= 15) begin
        roll = $urandom_range(0, 99);
        step = (roll < 5) ? 0 : $urandom_range(1, 900);
        gen_time = (roll >= 5 && roll < 10) ? $urandom : gen_time + step;
        drop_by = $urandom_range(0, 400);
        if ($urandom_range(0, 99) < 8 || gen_charge < drop_by) begin
          gen_charge = 16'($urandom);
        end else begin
          gen_charge = gen_charge - 16'(drop_by);
        end
        roll = $urandom_range(0, 99);
        rq.lit = (roll < 35) ? 16'd0 :
                 (roll < 75) ? 16'($urandom_range(0, step)) : 16'($urandom);
        rq.uptime = gen_time;
        rq.charge = gen_charge;
      end
      if (rq.opcode == dil_pkg::OP_READ_ENTRY && gen_fill > 0 && $urandom_range(0, 3) != 0) begin
        rq.index = 9'($urandom_range(0, gen_fill - 1));
      end
      queue_request(rq);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples, %0d entry reads (%0d on held samples), %0d statistic reads,",
             n_samples, n_entry_reads, n_entry_hits, n_stat_reads);
    $display("%0d clears, %0d error/unused requests; ring filled to %0d; %0d results checked",
             n_clears, n_other, peak_held, replies_checked);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
